// ===== rtl/rsna_pkg.sv =====
// Shared types and constants for the RDS station name assembler.
// Used by the group filter, the name assembly stage and the top level.
`timescale 1ns / 1ps
package rsna_pkg;

	// Field widths of one RDS group and of one result.
	localparam int unsigned BLOCK_W = 16;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned SEG_N = 4;
	localparam int unsigned NAME_W = 64;

	// Group type code that carries the station name.
	localparam logic [3:0] GROUP_TYPE_NAME = 4'd0;

	// Segment address of the last character pair in the name.
	localparam logic [1:0] SEG_LAST = 2'd3;

	// Stream widths, padded to whole bytes.
	localparam int unsigned IN_TDATA_W = 64;
	localparam int unsigned OUT_TDATA_W = 88;

	// Decoded view of one accepted group, passed to the name stage.
	typedef struct packed {
		logic       changed;
		logic       name_group;
		logic [1:0] seg;
	} grp_info_t;

	typedef logic [0:SEG_N-1][BLOCK_W-1:0] name_t;

endpackage

// ===== rtl/rsna_group_filter.sv =====
// Group filter: tracks the PI code and detects whether a group differs from the last one.
// Depends on rsna_pkg for block widths and the group info struct.
`timescale 1ns / 1ps
module rsna_group_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [rsna_pkg::BLOCK_W-1:0]  block_a,
	input  logic [rsna_pkg::BLOCK_W-1:0]  block_b,
	input  logic [rsna_pkg::BLOCK_W-1:0]  block_c,
	input  logic [rsna_pkg::BLOCK_W-1:0]  block_d,
	output rsna_pkg::grp_info_t           info,
	output logic [rsna_pkg::BLOCK_W-1:0]  pi_next,
	output logic                          pi_valid_next
);

	logic [rsna_pkg::BLOCK_W-1:0] last_q [0:3];
	logic [rsna_pkg::BLOCK_W-1:0] held_pi_q;
	logic                         held_valid_q;
	logic                         pi_zero;
	logic                         differs;

	// A zero PI compares the group against a cleared copy.
	assign pi_zero = (block_a == '0);
	always_comb begin
		if (pi_zero) begin
			differs = (block_b != '0) || (block_c != '0) || (block_d != '0);
		end else begin
			differs = (last_q[0] != block_a) || (last_q[1] != block_b) ||
				(last_q[2] != block_c) || (last_q[3] != block_d);
		end
	end

	// PI tracking: a repeat confirms, a new code replaces and drops validity.
	always_comb begin
		pi_next = held_pi_q;
		pi_valid_next = held_valid_q;
		if (!pi_zero) begin
			if (held_pi_q == block_a) begin
				pi_valid_next = 1'b1;
			end else begin
				pi_next = block_a;
				pi_valid_next = 1'b0;
			end
		end
	end

	assign info.changed = differs;
	assign info.name_group = (block_b[15:12] == rsna_pkg::GROUP_TYPE_NAME);
	assign info.seg = block_b[1:0];

	// After every transfer the stored copy equals the group just taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q[0] <= '0;
			last_q[1] <= '0;
			last_q[2] <= '0;
			last_q[3] <= '0;
			held_pi_q <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			last_q[0] <= block_a;
			last_q[1] <= block_b;
			last_q[2] <= block_c;
			last_q[3] <= block_d;
			held_pi_q <= pi_next;
			held_valid_q <= pi_valid_next;
		end
	end

endmodule

// ===== rtl/rsna_name_asm.sv =====
// Name assembly: pending, confirmed and published copies of the eight-character name.
// Depends on rsna_pkg for the name type and the group info struct.
`timescale 1ns / 1ps
module rsna_name_asm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  rsna_pkg::grp_info_t           info,
	input  logic [rsna_pkg::BLOCK_W-1:0]  chars,
	output logic [rsna_pkg::NAME_W-1:0]   name_next,
	output logic                          updated
);

	rsna_pkg::name_t pend_q;
	rsna_pkg::name_t conf_q;
	rsna_pkg::name_t pub_q;
	rsna_pkg::name_t pend_next;
	rsna_pkg::name_t conf_next;
	rsna_pkg::name_t pub_next;
	logic [rsna_pkg::BLOCK_W-1:0] pend_pair;
	logic decode;
	logic match;
	logic both_differ;

	assign decode = info.changed && info.name_group;
	assign pend_pair = pend_q[info.seg];
	assign match = (pend_pair == chars);
	assign both_differ = (pend_pair[15:8] != chars[15:8]) && (pend_pair[7:0] != chars[7:0]);

	// Confirm on a repeat, replace the pending pair only when both characters are new.
	always_comb begin
		pend_next = pend_q;
		conf_next = conf_q;
		pub_next = pub_q;
		updated = 1'b0;
		if (decode) begin
			if (match) begin
				conf_next[info.seg] = chars;
				if (info.seg == rsna_pkg::SEG_LAST && conf_next != pub_q) begin
					pub_next = conf_next;
					updated = 1'b1;
				end
			end
			if (both_differ) begin
				pend_next[info.seg] = chars;
			end
		end
	end

	assign name_next = pub_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			conf_q <= '0;
			pub_q <= '0;
		end else if (accept) begin
			pend_q <= pend_next;
			conf_q <= conf_next;
			pub_q <= pub_next;
		end
	end

endmodule

// ===== rtl/rds_station_name_assembler_core.sv =====
// Top level of the RDS station name assembler: input handshake and result register.
// Depends on rsna_pkg, rsna_group_filter and rsna_name_asm.
`timescale 1ns / 1ps
// Usage:
// The slave stream carries one RDS group per transfer: block_a in the low 16 bits
// of s_tdata, then block_b, block_c and block_d. Each group yields exactly one
// result on the master stream: held PI code, PI valid flag, published station
// name, a flag for a name update and a flag for a changed group.
// The result of a group is in the result register in the cycle after its transfer.
// The block takes one group per cycle while the receiver takes results; the only
// limit is the result register, which can be refilled in the same cycle it is taken.
// When the receiver stalls, the result register holds and s_tready falls, so no
// further group is taken until the pending result leaves.
// Reset clears the stored group, the PI state and all name copies to zero and
// empties the result register.
module rds_station_name_assembler_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// block_a[15:0], block_b[31:16], block_c[47:32], block_d[63:48]
	input  logic [rsna_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pi_code[15:0], pi_valid[16], ps_name[80:17], name_updated[81],
	// group_changed[82], zero[87:83]
	output logic [rsna_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	logic accept;
	rsna_pkg::grp_info_t info;
	logic [rsna_pkg::BLOCK_W-1:0] pi_next;
	logic pi_valid_next;
	logic [rsna_pkg::NAME_W-1:0] name_next;
	logic updated;
	logic out_valid_q;
	logic [rsna_pkg::OUT_TDATA_W-1:0] out_data_q;

	// A group is taken whenever the result register is empty or being drained.
	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	rsna_group_filter u_filter (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.block_a       (s_tdata[15:0]),
		.block_b       (s_tdata[31:16]),
		.block_c       (s_tdata[47:32]),
		.block_d       (s_tdata[63:48]),
		.info          (info),
		.pi_next       (pi_next),
		.pi_valid_next (pi_valid_next)
	);

	rsna_name_asm u_name (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.info      (info),
		.chars     (s_tdata[63:48]),
		.name_next (name_next),
		.updated   (updated)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'b0, info.changed, updated, name_next, pi_valid_next, pi_next};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

`ifndef SYNTH
	// Every transfer in leaves a result in the register at the next edge.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted group produced no result");

	// The name can change only on a group that differs from the last one.
	a_update_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[81]) |-> m_tdata[82])
		else $error("name updated on an unchanged group");

	// A valid PI is never the zero code.
	a_pi_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] != 16'h0000))
		else $error("PI marked valid with zero code");
`endif

endmodule
